// ----- hdl/ifs_pkg.sv -----
`default_nettype none
package ifs_pkg;

  localparam int SINCOS_STAGES = 24;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [64:0] CLAMP_BOUND = 65'sd65536000000000000;

  localparam logic [1:0] REG_GRAVITY  = 2'd0;
  localparam logic [1:0] REG_STATIC   = 2'd1;
  localparam logic [1:0] REG_KINETIC  = 2'd2;
  localparam logic [1:0] REG_STEP     = 2'd3;

  typedef struct packed {
    logic               valid;
    logic signed [63:0] pos;
    logic signed [63:0] vel;
    logic signed [31:0] ang;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_t;

  typedef struct packed {
    logic [23:0] gravity;
    logic [17:0] scoef;
    logic [17:0] kcoef;
    logic [31:0] tstep;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [63:0] pos;
    logic signed [63:0] vel;
    logic signed [31:0] ang;
    logic               pclamp;
    logic               vclamp;
  } res_t;

  function automatic logic signed [33:0] ifs_atan(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ifs_cordic_cell.sv -----
`default_nettype none
module ifs_cordic_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [4:0]       stage,
  input  wire ifs_pkg::cordic_t din,
  output ifs_pkg::cordic_t      dout
);
  import ifs_pkg::*;

  cordic_t nxt;

  always_comb begin
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - ($signed(din.y) >>> stage);
      nxt.y = din.y + ($signed(din.x) >>> stage);
      nxt.z = din.z - ifs_atan(stage);
    end else begin
      nxt.x = din.x + ($signed(din.y) >>> stage);
      nxt.y = din.y - ($signed(din.x) >>> stage);
      nxt.z = din.z + ifs_atan(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.ctx.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ifs_dynamics.sv -----
`default_nettype none
module ifs_dynamics (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire ifs_pkg::cfg_t    cfg,
  input  wire ifs_pkg::cordic_t din,
  output ifs_pkg::res_t         dout
);
  import ifs_pkg::*;

  function automatic logic signed [31:0] rnd30(input logic signed [58:0] p);
    logic [58:0] m;
    logic [31:0] r;
    m = p[58] ? 59'(-p) : 59'(p);
    r = 32'((m + 59'd536870912) >> 30);
    return p[58] ? -$signed(r) : $signed(r);
  endfunction

  ctx_t c [8];

  logic signed [58:0]  prod_g, prod_c;
  logic signed [31:0]  a_g2, lim2;
  logic signed [31:0]  a_g3;
  logic [47:0]         lhs3;
  logic signed [51:0]  rhs3;
  logic [49:0]         frp3;
  logic signed [35:0]  op4;
  logic                move4, vzero4;
  logic [63:0]         prod5;
  logic                neg5, move5, vzero5;
  logic signed [63:0]  vnew6, vnew7, vnew8;
  logic [63:0]         lo7, hi7;
  logic                neg7;
  logic signed [63:0]  dp8;

  logic signed [33:0]  sn1, cs1;
  logic [31:0]         agm, limm;
  logic [33:0]         fr4;
  logic signed [35:0]  ag36, fr36, op_n;
  logic [35:0]         opm;
  logic [32:0]         r6;
  logic signed [63:0]  d6, v6;
  logic signed [64:0]  s6;
  logic signed [63:0]  vs6, vnew_n;
  logic [63:0]         vm7;
  logic [64:0]         r8;
  logic [63:0]         r8s;
  logic signed [64:0]  s9;
  res_t                res_n;

  assign sn1  = din.flip ? -din.y : din.y;
  assign cs1  = din.flip ? -din.x : din.x;
  assign agm  = a_g2[31] ? 32'(-a_g2) : 32'(a_g2);
  assign limm = lim2[31] ? 32'(-lim2) : 32'(lim2);

  assign fr4  = 34'((frp3 + 50'd32768) >> 16);
  assign ag36 = 36'(a_g3);
  assign fr36 = $signed({2'b00, fr4});
  always_comb begin
    if (c[2].vel == 64'sd0) begin
      op_n = ag36;
    end else if (c[2].vel[63]) begin
      op_n = ag36 + fr36;
    end else begin
      op_n = ag36 - fr36;
    end
  end
  assign opm = op4[35] ? 36'(-op4) : 36'(op4);

  // velocity update with stop at zero on sign change
  assign r6 = 33'(({1'b0, prod5} + 65'h80000000) >> 32);
  assign d6 = neg5 ? -$signed(64'(r6)) : $signed(64'(r6));
  assign v6 = c[4].vel;
  assign s6 = {v6[63], v6} + {d6[63], d6};
  always_comb begin
    if (s6[64] != s6[63]) begin
      vs6 = s6[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      vs6 = s6[63:0];
    end
    if (vzero5) begin
      vnew_n = move5 ? d6 : 64'sd0;
    end else if ((!v6[63] && vs6[63]) || (v6[63] && !vs6[63] && vs6 != 64'sd0)) begin
      vnew_n = 64'sd0;
    end else begin
      vnew_n = vs6;
    end
  end

  assign vm7 = vnew6[63] ? 64'd0 - 64'(vnew6) : 64'(vnew6);
  assign r8  = {1'b0, hi7} + 65'(({1'b0, lo7} + 65'h80000000) >> 32);
  assign r8s = (r8 > 65'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : r8[63:0];

  assign s9 = {c[7].pos[63], c[7].pos} + {dp8[63], dp8};
  always_comb begin
    res_n.valid = c[7].valid;
    res_n.ang   = c[7].ang;
    res_n.pclamp = (s9 > CLAMP_BOUND) || (s9 < -CLAMP_BOUND);
    if (s9 > CLAMP_BOUND) begin
      res_n.pos = CLAMP_BOUND[63:0];
    end else if (s9 < -CLAMP_BOUND) begin
      res_n.pos = 64'(-CLAMP_BOUND);
    end else begin
      res_n.pos = s9[63:0];
    end
    res_n.vclamp = (65'(vnew8) > CLAMP_BOUND) || (65'(vnew8) < -CLAMP_BOUND);
    if (65'(vnew8) > CLAMP_BOUND) begin
      res_n.vel = CLAMP_BOUND[63:0];
    end else if (65'(vnew8) < -CLAMP_BOUND) begin
      res_n.vel = 64'(-CLAMP_BOUND);
    end else begin
      res_n.vel = vnew8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) begin
        c[k].valid <= 1'b0;
      end
      dout.valid <= 1'b0;
    end else if (en) begin
      c[0] <= din.ctx;
      for (int k = 1; k < 8; k++) begin
        c[k] <= c[k-1];
      end
      prod_g <= $signed({1'b0, cfg.gravity}) * sn1;
      prod_c <= $signed({1'b0, cfg.gravity}) * cs1;
      a_g2   <= rnd30(prod_g);
      lim2   <= rnd30(prod_c);
      a_g3   <= a_g2;
      lhs3   <= {agm[31:0], 16'd0};
      rhs3   <= $signed({1'b0, cfg.scoef}) * lim2;
      frp3   <= 50'(cfg.kcoef) * 50'(limm);
      op4    <= op_n;
      move4  <= $signed({4'd0, lhs3}) > rhs3;
      vzero4 <= c[2].vel == 64'sd0;
      prod5  <= 64'(opm[31:0]) * 64'(cfg.tstep);
      neg5   <= op4[35];
      move5  <= move4;
      vzero5 <= vzero4;
      vnew6  <= vnew_n;
      lo7    <= 64'(vm7[31:0]) * 64'(cfg.tstep);
      hi7    <= 64'(vm7[63:32]) * 64'(cfg.tstep);
      neg7   <= vnew6[63];
      vnew7  <= vnew6;
      dp8    <= neg7 ? -$signed(r8s) : $signed(r8s);
      vnew8  <= vnew7;
      dout   <= res_n;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/incline_friction_step.sv -----
`default_nettype none
// one semi-implicit euler step of a particle on an incline with stick-slip friction
// input channel: in_valid / in_stall with position, velocity (q47.16) and angle (q2.29)
// output channel: out_valid / out_stall with the clamped position and velocity,
// the angle passed through, two clamp flags and the running clamp total
// config: cfg_write with cfg_index 0 gravity, 1 static coef, 2 kinetic coef,
// 3 time step; any write clears the clamp total; write only while idle
// one request is taken per cycle while in_stall is low; a request passes through
// the chain of SINCOS_STAGES cordic cells (24 cordic cells), then the nine
// stage friction / integration pipeline behind it, then the output register
// when out_stall holds a result, one more result lands in a skid register,
// then in_stall rises and the whole pipeline freezes until the output drains
// reset restores the default registers, clears the clamp total and empties the pipeline
module incline_friction_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [63:0] position,
  input  wire logic signed [63:0] velocity,
  input  wire logic signed [31:0] angle,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [63:0]      next_position,
  output logic signed [63:0]      next_velocity,
  output logic signed [31:0]      angle_out,
  output logic                    position_clamped,
  output logic                    velocity_clamped,
  output logic [31:0]             clamp_total,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import ifs_pkg::*;

  typedef struct packed {
    logic signed [63:0] pos;
    logic signed [63:0] vel;
    logic signed [31:0] ang;
    logic               pclamp;
    logic               vclamp;
    logic [31:0]        total;
  } item_t;

  cfg_t        cfg;
  logic [31:0] count, count_next;
  logic [33:0] count_sum;
  logic        en, push, take, skid_full;
  item_t       skid, res_item;
  cordic_t     head;
  cordic_t     chain [SINCOS_STAGES+1];
  res_t        res;
  logic signed [33:0] zin;

  assign en       = !skid_full;
  assign in_stall = skid_full;
  assign push     = en && res.valid;
  assign take     = out_valid && !out_stall;

  // angle doubled to q30 and folded into the half plane
  assign zin = {angle[31], angle, 1'b0};
  always_comb begin
    head.ctx.valid = in_valid;
    head.ctx.pos   = position;
    head.ctx.vel   = velocity;
    head.ctx.ang   = angle;
    head.x         = CORDIC_GAIN;
    head.y         = 34'sd0;
    if (zin > HALF_PI_Q30) begin
      head.z    = zin - PI_Q30;
      head.flip = 1'b1;
    end else if (zin < -HALF_PI_Q30) begin
      head.z    = zin + PI_Q30;
      head.flip = 1'b1;
    end else begin
      head.z    = zin;
      head.flip = 1'b0;
    end
  end
  assign chain[0] = head;

  for (genvar k = 0; k < SINCOS_STAGES; k++) begin : g_cell
    ifs_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .stage (5'(k)),
      .din   (chain[k]),
      .dout  (chain[k+1])
    );
  end

  ifs_dynamics u_dyn (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .cfg  (cfg),
    .din  (chain[SINCOS_STAGES]),
    .dout (res)
  );

  assign count_sum  = {2'b00, count} + 34'(res.pclamp) + 34'(res.vclamp);
  assign count_next = (count_sum > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : count_sum[31:0];

  always_comb begin
    res_item.pos    = res.pos;
    res_item.vel    = res.vel;
    res_item.ang    = res.ang;
    res_item.pclamp = res.pclamp;
    res_item.vclamp = res.vclamp;
    res_item.total  = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity <= 24'd642908;
      cfg.scoef   <= 18'd0;
      cfg.kcoef   <= 18'd0;
      cfg.tstep   <= 32'd4294967;
      count       <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRAVITY: cfg.gravity <= cfg_data[23:0];
        REG_STATIC:  cfg.scoef   <= cfg_data[17:0];
        REG_KINETIC: cfg.kcoef   <= cfg_data[17:0];
        REG_STEP:    cfg.tstep   <= cfg_data;
        default:     cfg.tstep   <= cfg.tstep;
      endcase
      count <= 32'd0;
    end else if (push) begin
      count <= count_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        {next_position, next_velocity, angle_out, position_clamped,
         velocity_clamped, clamp_total} <= skid;
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        {next_position, next_velocity, angle_out, position_clamped,
         velocity_clamped, clamp_total} <= res_item;
        out_valid <= 1'b1;
      end else begin
        skid      <= res_item;
        skid_full <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry held without an output request");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && out_stall && !skid_full) |=> skid_full)
    else $error("result dropped while output stalled");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!push && !cfg_write) |=> count == $past(count))
    else $error("clamp total changed without a result");

endmodule
`default_nettype wire

// ----- tb/tb_incline_friction_step.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_incline_friction_step;
  import ifs_pkg::*;

  class friction_scoreboard;
    typedef struct {
      logic signed [63:0] pos;
      logic signed [63:0] vel;
      logic signed [31:0] ang;
      logic               pclamp;
      logic               vclamp;
      logic [31:0]        total;
    } particle_t;

    logic [23:0] gravity;
    logic [17:0] scoef;
    logic [17:0] kcoef;
    logic [31:0] tstep;
    logic [31:0] clamp_count;
    particle_t   pending[$];
    int          errors;

    function new();
      gravity = 24'd642908;
      scoef = 0;
      kcoef = 0;
      tstep = 32'd4294967;
      clamp_count = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_GRAVITY: gravity = data[23:0];
        REG_STATIC:  scoef = data[17:0];
        REG_KINETIC: kcoef = data[17:0];
        REG_STEP:    tstep = data;
      endcase
      clamp_count = 0;
    endfunction

    // round half away from zero of x / 2^sh
    function automatic logic signed [127:0] round_shift(logic signed [127:0] x, int sh);
      logic [127:0] m;
      m = x < 0 ? -x : x;
      m = (m + (128'd1 << (sh - 1))) >> sh;
      return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] scale_dt(logic signed [63:0] a);
      logic [127:0] m;
      m = a < 0 ? -$signed({{64{a[63]}}, a}) : {64'd0, a};
      m = (m * tstep + 128'h8000_0000) >> 32;
      if (m > 128'h7FFF_FFFF_FFFF_FFFF) m = 128'h7FFF_FFFF_FFFF_FFFF;
      return a < 0 ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [63:0] x, output logic hit);
      hit = 1;
      if (x > 64'sd65536000000000000) return 64'sd65536000000000000;
      if (x < -64'sd65536000000000000) return -64'sd65536000000000000;
      hit = 0;
      return x;
    endfunction

    function void note_request(logic signed [63:0] s, logic signed [63:0] v,
                               logic signed [31:0] angle);
      logic signed [63:0] z, x, y, t, sn, cs, ag, lim, fr, acc, vn;
      logic signed [127:0] lhs, rhs;
      logic flip;
      particle_t p;
      z = 2 * 64'(angle);
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1686629713) begin
        z = z - 64'sd3373259426;
        flip = 1;
      end else if (z < -64'sd1686629713) begin
        z = z + 64'sd3373259426;
        flip = 1;
      end
      for (int i = 0; i < SINCOS_STAGES && i < 32; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - 64'(ifs_atan(i[4:0]));
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + 64'(ifs_atan(i[4:0]));
        end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
      ag = round_shift($signed({104'd0, gravity}) * sn, 30);
      lim = round_shift($signed({104'd0, gravity}) * cs, 30);
      if (v == 0) begin
        lhs = (ag < 0 ? -ag : ag) * 128'sd65536;
        rhs = $signed({110'd0, scoef}) * lim;
        if (lhs > rhs) v = scale_dt(ag);
      end else begin
        fr = round_shift($signed({110'd0, kcoef}) * (lim < 0 ? -lim : lim), 16);
        acc = ag + (v > 0 ? -fr : fr);
        vn = sat_add(v, scale_dt(acc));
        if ((v > 0 && vn < 0) || (v < 0 && vn > 0)) v = 0;
        else v = vn;
      end
      p.pos = clamp(sat_add(s, scale_dt(v)), p.pclamp);
      p.vel = clamp(v, p.vclamp);
      p.ang = angle;
      if (p.pclamp && clamp_count != '1) clamp_count++;
      if (p.vclamp && clamp_count != '1) clamp_count++;
      p.total = clamp_count;
      pending.push_back(p);
    endfunction

    function void check_result(logic signed [63:0] pos, vel, logic signed [31:0] ang,
                               logic pc, vc, logic [31:0] total);
      particle_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pos %0d", $time, pos);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pos !== e.pos) begin
        $display("%0t: next_position exp %0d got %0d", $time, e.pos, pos); errors++;
      end
      if (vel !== e.vel) begin
        $display("%0t: next_velocity exp %0d got %0d", $time, e.vel, vel); errors++;
      end
      if (ang !== e.ang) begin
        $display("%0t: angle_out exp %0d got %0d", $time, e.ang, ang); errors++;
      end
      if (pc !== e.pclamp) begin
        $display("%0t: position_clamped exp %0b got %0b", $time, e.pclamp, pc); errors++;
      end
      if (vc !== e.vclamp) begin
        $display("%0t: velocity_clamped exp %0b got %0b", $time, e.vclamp, vc); errors++;
      end
      if (total !== e.total) begin
        $display("%0t: clamp_total exp %0d got %0d", $time, e.total, total); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = SINCOS_STAGES + 10;
  localparam int WATCHDOG = 5000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [63:0] position = 0;
  logic signed [63:0] velocity = 0;
  logic signed [31:0] angle = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [63:0] next_position, next_velocity;
  logic signed [31:0] angle_out;
  logic position_clamped, velocity_clamped;
  logic [31:0] clamp_total;
  logic cfg_write = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  logic timed_out = 0;
  friction_scoreboard board;

  incline_friction_step i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_result(next_position, next_velocity, angle_out,
                           position_clamped, velocity_clamped, clamp_total);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) timed_out = 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // in_valid stays high after the request so the next one can follow directly
  task automatic send_particle(logic signed [63:0] s, v, logic signed [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    position <= s;
    velocity <= v;
    angle <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(s, v, a);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    board.write_reg(idx, data);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  function automatic logic signed [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly realistic values, sometimes full-range noise
  function automatic logic signed [63:0] rand_state(int zero_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < zero_pct) return 0;
    if (pick < zero_pct + 15) return rand64();
    if (pick < zero_pct + 25)
      return $signed($urandom_range(1)) ? 64'sd65536000000000000 + $signed(64'($urandom()))
                                         : -64'sd65536000000000000 - $signed(64'($urandom()));
    return $signed(64'(rand64() >>> $urandom_range(60, 20)));
  endfunction

  function automatic logic signed [31:0] rand_angle();
    if ($urandom_range(9) == 0) return $urandom();
    return $signed(32'($urandom_range(2 * 1686629713))) - 32'sd1686629713;
  endfunction

  task automatic random_config(int extreme);
    write_reg(REG_GRAVITY, extreme ? 32'hFF_FFFF : 1 + $urandom_range(24'hFF_FFFE));
    write_reg(REG_STATIC, extreme ? 32'h3_FFFF : $urandom_range(18'h3_FFFF));
    write_reg(REG_KINETIC, extreme ? 32'h3_FFFF : $urandom_range(18'h2_0000));
    write_reg(REG_STEP, extreme ? 32'hFFFF_FFFF : 1 + $urandom_range(32'hFFFF_FFFE));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_particle(rand_state(10), rand_state(30), rand_angle());
  endtask

  initial begin
    board = new();
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset config, then extremes and special cases
    send_particle(0, 0, 0);
    send_particle(0, 0, 32'sd1686629713);
    send_particle(0, 0, -32'sd1686629713);
    send_particle(0, 0, 32'sh7FFF_FFFF);
    send_particle(0, 0, 32'sh8000_0000);
    drain();
    write_reg(REG_STATIC, 32'h0_8000);
    write_reg(REG_KINETIC, 32'h0_4000);
    send_particle(0, 0, 32'sd100000000);
    send_particle(0, 0, 32'sd400000000);
    send_particle(100, 0, 32'sd1200000000);
    send_particle(0, 64'sd65536, 32'sd100000);
    send_particle(0, -64'sd65536, 32'sd100000);
    send_particle(0, 64'sd1, 32'sd0);
    send_particle(0, -64'sd1, -32'sd300000000);
    send_particle(64'sh7FFF_FFFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF, 32'sd1000);
    send_particle(64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0000, -32'sd1000);
    send_particle(64'sd65536000000000000, 0, 0);
    send_particle(-64'sd65536000000000001, 64'sd65536000000000001, 0);
    drain();
    random_config(1);
    send_particle(0, 0, 32'sd800000000);
    send_particle(-64'sd5, 64'sh7FFF_FFFF_FFFF_FFFF, -32'sd1686629713);
    send_particle(64'sh7FFF_FFFF_FFFF_FFFF, -64'sd3, 32'sh7FFF_FFFF);
    send_particle(0, 0, 32'sh8000_0000);
    drain();
    write_reg(REG_GRAVITY, 1);
    write_reg(REG_STEP, 1);
    write_reg(REG_STATIC, 0);
    write_reg(REG_KINETIC, 0);
    send_particle(0, 0, 32'sd1686629713);
    send_particle(-1, 1, 32'sd5);
    drain();

    send_idle_pct = 29; recv_stall_pct = 58;
    for (int k = 0; k < 3; k++) begin
      random_config(0);
      random_phase(115);
      drain();
    end
    send_idle_pct = 58; recv_stall_pct = 29;
    for (int k = 0; k < 3; k++) begin
      random_config(0);
      random_phase(115);
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int k = 0; k < 3; k++) begin
      random_config(k == 2);
      random_phase(115);
      drain();
    end

    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ----- files.f -----
hdl/ifs_pkg.sv
hdl/ifs_cordic_cell.sv
hdl/ifs_dynamics.sv
hdl/incline_friction_step.sv
tb/tb_incline_friction_step.sv
